@@ hw/rtl/slcfd_pkg.sv @@
package slcfd_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam int FRAME_SLOTS = 2;
    localparam int SLOT_CW     = $clog2(FRAME_SLOTS + 1);
    localparam int DESC_PW     = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int BUF_DEPTH   = FRAME_SLOTS * (2 ** IDX_W);

    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PW      = $clog2(OUT_DEPTH);
    localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT    = 8'h00;

    typedef enum logic [2:0] {
        PH_WAIT_AA = 3'd0,
        PH_WAIT_55 = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } phase_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ftype;
        logic [LEN_W-1:0]  len;
        logic              bank;
    } frame_desc_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ftype;
        logic [LEN_W-1:0]  len;
        logic              has_payload;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } result_t;

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (v[BYTE_W-1])
            begin
                v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[BYTE_W-2:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/slcfd_front.sv @@
module slcfd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [7:0]                  rx_byte,
    input  logic                        frame_done,
    output logic                        full,
    output slcfd_pkg::buf_wr_t          wr,
    output logic                        desc_push,
    output slcfd_pkg::frame_desc_t      desc
);
    import slcfd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    wpos_reg, wpos_next;
    logic [BYTE_W-1:0]   crc_reg, crc_next;
    logic                bank_reg, bank_next;
    logic [SLOT_CW-1:0]  slots_reg, slots_next;
    logic                accept;
    logic                crc_ok;
    logic [LEN_W-1:0]    wpos_inc;

    assign full     = (slots_reg == SLOT_CW'(FRAME_SLOTS));
    assign accept   = push && !full;
    assign crc_ok   = (rx_byte == crc_reg);
    assign wpos_inc = wpos_reg + LEN_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT_AA:
                begin
                    if (rx_byte == SYNC_FIRST)
                    begin
                        phase_next = PH_WAIT_55;
                    end
                end
                PH_WAIT_55:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else if (rx_byte != SYNC_FIRST)
                    begin
                        phase_next = PH_WAIT_AA;
                    end
                end
                PH_TYPE:
                begin
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if ({1'b0, rx_byte} > 9'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_WAIT_AA;
                    end
                    else if (rx_byte == '0)
                    begin
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (wpos_inc >= len_reg || wpos_inc >= LEN_W'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_CRC;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT_AA;
                end
            endcase
        end
    end

    always_comb
    begin
        type_next = type_reg;
        len_next  = len_reg;
        wpos_next = wpos_reg;
        crc_next  = crc_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next = rx_byte;
                    crc_next  = crc8_step(CRC_INIT, rx_byte);
                end
                PH_LEN:
                begin
                    if ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD))
                    begin
                        len_next  = rx_byte[LEN_W-1:0];
                        wpos_next = '0;
                        crc_next  = crc8_step(crc_reg, rx_byte);
                    end
                end
                PH_PAYLOAD:
                begin
                    wpos_next = wpos_inc;
                    crc_next  = crc8_step(crc_reg, rx_byte);
                end
                PH_CRC:
                begin
                    if (crc_ok)
                    begin
                        bank_next = !bank_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        wr.en       = accept && (phase_reg == PH_PAYLOAD)
                      && (wpos_reg < LEN_W'(MAX_PAYLOAD));
        wr.bank     = bank_reg;
        wr.addr     = wpos_reg[IDX_W-1:0];
        wr.data     = rx_byte;
        desc_push   = accept && (phase_reg == PH_CRC) && crc_ok;
        desc.ftype  = type_reg;
        desc.len    = len_reg;
        desc.bank   = bank_reg;
        slots_next  = slots_reg + SLOT_CW'(desc_push) - SLOT_CW'(frame_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_AA;
            type_reg  <= '0;
            len_reg   <= '0;
            wpos_reg  <= '0;
            crc_reg   <= '0;
            bank_reg  <= 1'b0;
            slots_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            wpos_reg  <= wpos_next;
            crc_reg   <= crc_next;
            bank_reg  <= bank_next;
            slots_reg <= slots_next;
        end
    end

endmodule

@@ hw/rtl/slcfd_desc_q.sv @@
module slcfd_desc_q (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  slcfd_pkg::frame_desc_t      wr_data,
    input  logic                        rd_en,
    output logic                        empty,
    output slcfd_pkg::frame_desc_t      rd_data
);
    import slcfd_pkg::*;

    frame_desc_t         entry_reg [FRAME_SLOTS];
    logic [DESC_PW-1:0]  wptr_reg, wptr_next;
    logic [DESC_PW-1:0]  rptr_reg, rptr_next;
    logic [SLOT_CW-1:0]  cnt_reg, cnt_next;

    function automatic logic [DESC_PW-1:0] ptr_inc(input logic [DESC_PW-1:0] p);
        return (p == DESC_PW'(FRAME_SLOTS - 1)) ? '0 : p + DESC_PW'(1);
    endfunction

    assign empty   = (cnt_reg == '0);
    assign rd_data = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr_en ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next = rd_en ? ptr_inc(rptr_reg) : rptr_reg;
        cnt_next  = cnt_reg + SLOT_CW'(wr_en) - SLOT_CW'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/slcfd_back.sv @@
module slcfd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  slcfd_pkg::buf_wr_t          wr,
    input  logic                        desc_empty,
    input  slcfd_pkg::frame_desc_t      desc,
    output logic                        desc_pop,
    output logic                        frame_done,
    input  logic                        res_pop,
    output logic                        res_empty,
    output slcfd_pkg::result_t          res
);
    import slcfd_pkg::*;

    logic [BYTE_W-1:0]   buf_mem [BUF_DEPTH];
    logic [BYTE_W-1:0]   rd_data_reg;

    logic                active_reg, active_next;
    frame_desc_t         cur_reg, cur_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic                s1_valid_reg;
    result_t             s1_reg, s1_next;

    result_t             fifo_reg [OUT_DEPTH];
    logic [OUT_PW-1:0]   fwptr_reg, frptr_reg;
    logic [OUT_CW-1:0]   fcnt_reg, fcnt_next;
    result_t             fifo_in;
    logic                fifo_we, fifo_re;

    logic                space;
    logic                issue;
    logic                is_last;

    assign space    = (fcnt_reg + OUT_CW'(s1_valid_reg)) < OUT_CW'(OUT_DEPTH);
    assign issue    = active_reg && space;
    assign is_last  = (cur_reg.len == '0) || ({1'b0, idx_reg} == cur_reg.len - LEN_W'(1));
    assign desc_pop = !active_reg && !desc_empty;
    assign frame_done = issue && is_last;

    always_comb
    begin
        active_next = active_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        if (desc_pop)
        begin
            active_next = 1'b1;
            cur_next    = desc;
            idx_next    = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_next.ftype       = cur_reg.ftype;
        s1_next.len         = cur_reg.len;
        s1_next.has_payload = (cur_reg.len != '0);
        s1_next.data        = '0;
        s1_next.idx         = idx_reg;
        s1_next.last        = is_last;
    end

    always_comb
    begin
        fifo_in      = s1_reg;
        fifo_in.data = s1_reg.has_payload ? rd_data_reg : '0;
        fifo_we      = s1_valid_reg;
        fifo_re      = res_pop && (fcnt_reg != '0);
        fcnt_next    = fcnt_reg + OUT_CW'(fifo_we) - OUT_CW'(fifo_re);
    end

    assign res_empty = (fcnt_reg == '0);
    assign res       = fifo_reg[frptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            buf_mem[{wr.bank, wr.addr}] <= wr.data;
        end
        if (issue)
        begin
            rd_data_reg <= buf_mem[{cur_reg.bank, idx_reg}];
            s1_reg      <= s1_next;
        end
        if (fifo_we)
        begin
            fifo_reg[fwptr_reg] <= fifo_in;
        end
        cur_reg <= cur_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            fwptr_reg    <= '0;
            frptr_reg    <= '0;
            fcnt_reg     <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            s1_valid_reg <= issue;
            fwptr_reg    <= fwptr_reg + OUT_PW'(fifo_we);
            frptr_reg    <= frptr_reg + OUT_PW'(fifo_re);
            fcnt_reg     <= fcnt_next;
        end
    end

endmodule

@@ hw/rtl/sync_len_crc8_frame_deframer_core.sv @@
// Takes one byte per cycle while full is low; full rises while two validated frames
// still wait to be drained from the two-bank payload buffer.
// The first beat of a frame follows its accepted CRC byte through the descriptor queue,
// frame register, read stage and output FIFO; then one beat per cycle while the FIFO has
// room, limited by the single read port of the payload buffer. Reset is asynchronous and
// active low; it clears all control state, while the payload buffer keeps its contents.
module sync_len_crc8_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  frame_type,
    output logic [6:0]  frame_length,
    output logic        has_payload,
    output logic [7:0]  payload_byte,
    output logic [5:0]  byte_index,
    output logic        last
);
    import slcfd_pkg::*;

    buf_wr_t       wr;
    logic          desc_push;
    frame_desc_t   desc_in;
    logic          desc_pop;
    logic          desc_empty;
    frame_desc_t   desc_out;
    logic          frame_done;
    result_t       res;

    slcfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rx_byte    (rx_byte),
        .frame_done (frame_done),
        .full       (full),
        .wr         (wr),
        .desc_push  (desc_push),
        .desc       (desc_in)
    );

    slcfd_desc_q u_desc_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc_in),
        .rd_en   (desc_pop),
        .empty   (desc_empty),
        .rd_data (desc_out)
    );

    slcfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .desc_empty (desc_empty),
        .desc       (desc_out),
        .desc_pop   (desc_pop),
        .frame_done (frame_done),
        .res_pop    (pop),
        .res_empty  (empty),
        .res        (res)
    );

    assign frame_type   = res.ftype;
    assign frame_length = res.len;
    assign has_payload  = res.has_payload;
    assign payload_byte = res.data;
    assign byte_index   = res.idx;
    assign last         = res.last;

endmodule

@@ hw/rtl/slcfd_checker.sv @@
module slcfd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  frame_type,
    input  logic [6:0]  frame_length,
    input  logic        has_payload,
    input  logic [7:0]  payload_byte,
    input  logic [5:0]  byte_index,
    input  logic        last
);

    a_hold_stalled_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(frame_type) && $stable(frame_length)
            && $stable(payload_byte) && $stable(byte_index) && $stable(last)))
        else $error("stalled result beat changed");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_payload) |-> (last && frame_length == 7'd0
            && byte_index == 6'd0 && payload_byte == 8'd0))
        else $error("empty frame beat malformed");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && has_payload) |-> (frame_length != 7'd0
            && {1'b0, byte_index} < frame_length))
        else $error("payload index outside frame length");

    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && has_payload) |-> (last == ({1'b0, byte_index} == frame_length - 7'd1)))
        else $error("last flag on wrong payload beat");

endmodule

bind sync_len_crc8_frame_deframer_core slcfd_checker u_slcfd_checker (.*);
